>>> rtl/byte_pattern_replace_assert.svh
// assertion macros for the bound assertion checker in rtl/bpr_checker.sv
`ifndef BYTE_PATTERN_REPLACE_ASSERT_SVH
`define BYTE_PATTERN_REPLACE_ASSERT_SVH

// same-cycle implication
`define BPR_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BPR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bpr_pkg.sv
package bpr_pkg;

   localparam int BYTE_W     = 8;
   localparam int REG_BYTES  = 8;
   localparam int LEN_W      = 4;
   localparam int TOTAL_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = BYTE_W + TOTAL_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LEN   = 2'd0,
      CSR_PATTERN_BYTES = 2'd1,
      CSR_REPLACE_BYTES = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic hit;
   } cell_ctrl_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data;
      logic               mark;
      logic               last;
      logic [TOTAL_W-1:0] total;
   } result_type;

endpackage

>>> rtl/bpr_cell.sv
module bpr_cell (
   input  logic                         clock,
   input  bpr_pkg::cell_ctrl_type       ctrl,
   input  logic [bpr_pkg::BYTE_W-1:0]   nbr_data,
   input  logic                         nbr_mark,
   input  logic [bpr_pkg::BYTE_W-1:0]   new_data,
   input  logic [bpr_pkg::BYTE_W-1:0]   rep_data,
   input  logic [bpr_pkg::BYTE_W-1:0]   pat_data,
   output logic [bpr_pkg::BYTE_W-1:0]   cell_data,
   output logic                         cell_mark,
   output logic                         pat_eq
);
   import bpr_pkg::*;

   logic [BYTE_W-1:0] data_ff, data_in;
   logic              mark_ff, mark_in;

   // a hit rewrites the shifted window with the replacement
   always_comb begin
      data_in = data_ff;
      mark_in = mark_ff;
      if (ctrl.hit) begin
         data_in = rep_data;
         mark_in = 1'b1;
      end else if (ctrl.load) begin
         data_in = new_data;
         mark_in = 1'b0;
      end else if (ctrl.shift) begin
         data_in = nbr_data;
         mark_in = nbr_mark;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      mark_ff <= mark_in;
   end

   assign cell_data = data_ff;
   assign cell_mark = mark_ff;
   assign pat_eq    = (data_ff == pat_data);

endmodule

>>> rtl/bpr_out_fifo.sv
module bpr_out_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bpr_pkg::result_type  push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 out_valid,
   output bpr_pkg::result_type  out_item
);
   import bpr_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];

endmodule

>>> rtl/byte_pattern_replace.sv
// a byte that leaves the window is written to the two-entry output queue, which offers it on rsp
// throughput: one byte per cycle if the queue has room, set by the single-step cell row shift
// end of buffer: the pending window (at most pattern_len-1 bytes, up to seven after the length
// shrinks mid-buffer) drains one byte per cycle while unstalled; req_tready stays low meanwhile
// reset (synchronous): empties window, output queue, cooldown and count; pattern_len
// returns to 1 and both byte registers to zero
module byte_pattern_replace #(
   parameter int PATTERN_MAX = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bpr_pkg::REQ_DATA_W-1:0]     req_tdata,   // [7:0] in_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bpr_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [7:0] out_byte, [23:8] replace_total
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,   // [0] was_replaced
   input  logic                               csr_we,
   input  logic [bpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bpr_pkg::*;

   localparam int FILL_W = $clog2(PATTERN_MAX + 1);

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   logic [LEN_W-1:0]                  len_ff;
   logic [CSR_DATA_W-1:0]             pat_ff, rep_ff;
   state_type                         state_ff, state_in;
   logic [FILL_W-1:0]                 fill_ff, fill_in;
   logic [FILL_W-1:0]                 cool_ff, cool_in;
   logic [TOTAL_W-1:0]                tally_ff, tally_in;

   logic [BYTE_W-1:0]                 cell_data [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]            cell_mark;
   logic [PATTERN_MAX-1:0]            pat_eq;
   logic [PATTERN_MAX-1:0]            win_ok;
   cell_ctrl_type                     ctrl [PATTERN_MAX];

   logic [LEN_W-1:0]                  len_eff, lm1, fill_ext;
   logic                              full_win, test, new_eq, hit;
   logic                              can_go, accept, drain_step, shift;
   logic [BYTE_W-1:0]                 new_pat;
   logic [TOTAL_W-1:0]                tally_hit;
   logic [FILL_W-1:0]                 fill_after, load_pos;
   logic                              fifo_full, push, pop;
   result_type                        push_item, out_item;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
         pat_ff <= '0;
         rep_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LEN:   len_ff <= csr_wdata[LEN_W-1:0];
            CSR_PATTERN_BYTES: pat_ff <= csr_wdata;
            CSR_REPLACE_BYTES: rep_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero length acts as one byte with matching off, large lengths clamp
   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(PATTERN_MAX)) begin
         len_eff = LEN_W'(PATTERN_MAX);
      end else begin
         len_eff = len_ff;
      end
   end

   assign lm1      = len_eff - LEN_W'(1);
   assign fill_ext = LEN_W'(fill_ff);
   assign full_win = (fill_ext >= lm1);
   assign test     = (fill_ext == lm1) && (cool_ff == '0);
   assign new_pat  = pat_ff[{lm1[2:0], 3'b000} +: BYTE_W];
   assign new_eq   = (req_tdata == new_pat);

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         win_ok[i] = pat_eq[i] || (LEN_W'(i) >= lm1);
      end
   end

   assign can_go     = !fifo_full;
   assign req_tready = can_go && (state_ff == ST_RUN);
   assign accept     = req_tvalid && req_tready;
   assign drain_step = (state_ff == ST_DRAIN) && can_go;
   assign hit        = accept && test && (len_ff != '0) && (&win_ok) && new_eq;
   assign shift      = (accept && full_win) || drain_step;

   assign tally_hit  = (hit && (tally_ff != {TOTAL_W{1'b1}})) ? tally_ff + TOTAL_W'(1)
                                                            : tally_ff;
   assign fill_after = full_win ? fill_ff : fill_ff + FILL_W'(1);
   // all ones when the window is empty and full, which matches no cell
   assign load_pos   = full_win ? fill_ff - FILL_W'(1) : fill_ff;

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      cool_in   = cool_ff;
      tally_in  = tally_ff;
      push      = 1'b0;
      push_item = '0;
      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               push           = full_win;
               push_item.data = hit ? rep_ff[BYTE_W-1:0]
                                    : ((fill_ff == '0) ? req_tdata : cell_data[0]);
               push_item.mark = hit || ((fill_ff != '0) && cell_mark[0]);
               if (req_tlast) begin
                  cool_in = '0;
                  if (fill_after == '0) begin
                     push_item.last  = 1'b1;
                     push_item.total = tally_hit;
                     tally_in        = '0;
                     fill_in         = '0;
                  end else begin
                     state_in = ST_DRAIN;
                     fill_in  = fill_after;
                     tally_in = tally_hit;
                  end
               end else begin
                  fill_in  = fill_after;
                  tally_in = tally_hit;
                  if (test) begin
                     cool_in = hit ? FILL_W'(lm1) : cool_ff;
                  end else if (cool_ff != '0) begin
                     cool_in = cool_ff - FILL_W'(1);
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (drain_step) begin
               push           = 1'b1;
               push_item.data = cell_data[0];
               push_item.mark = cell_mark[0];
               fill_in        = fill_ff - FILL_W'(1);
               if (fill_ff == FILL_W'(1)) begin
                  push_item.last  = 1'b1;
                  push_item.total = tally_ff;
                  tally_in        = '0;
                  state_in        = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
            fill_in  = '0;
            cool_in  = '0;
            tally_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         fill_ff  <= '0;
         cool_ff  <= '0;
         tally_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cool_ff  <= cool_in;
         tally_ff <= tally_in;
      end
   end

   // window cell row, cell 0 holds the oldest pending byte
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      logic [BYTE_W-1:0] nbr_data;
      logic              nbr_mark;
      logic [BYTE_W-1:0] rep_data;

      assign ctrl[i].shift = shift;
      assign ctrl[i].load  = accept && (load_pos == FILL_W'(i));
      assign ctrl[i].hit   = hit;

      if (i < PATTERN_MAX - 1) begin : g_nbr
         assign nbr_data = cell_data[i+1];
         assign nbr_mark = cell_mark[i+1];
      end else begin : g_end
         assign nbr_data = '0;
         assign nbr_mark = 1'b0;
      end

      if (i < REG_BYTES - 1) begin : g_rep
         assign rep_data = rep_ff[BYTE_W*(i+1) +: BYTE_W];
      end else begin : g_norep
         assign rep_data = '0;
      end

      bpr_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl[i]),
         .nbr_data  (nbr_data),
         .nbr_mark  (nbr_mark),
         .new_data  (req_tdata),
         .rep_data  (rep_data),
         .pat_data  (pat_ff[BYTE_W*i +: BYTE_W]),
         .cell_data (cell_data[i]),
         .cell_mark (cell_mark[i]),
         .pat_eq    (pat_eq[i])
      );
   end

   assign pop = rsp_tvalid && rsp_tready;

   bpr_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_item  (out_item)
   );

   assign rsp_tdata = {out_item.total, out_item.data};
   assign rsp_tlast = out_item.last;
   assign rsp_tuser = out_item.mark;

endmodule

>>> rtl/bpr_checker.sv
`include "byte_pattern_replace_assert.svh"

module bpr_assert_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bpr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           rsp_tuser
);
   import bpr_pkg::*;

   logic                         rsp_stall;
   logic [RSP_DATA_W+1:0]        rsp_bundle;
   logic [TOTAL_W-1:0]           rsp_total;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_bundle = {rsp_tdata, rsp_tlast, rsp_tuser};
   assign rsp_total  = rsp_tdata[RSP_DATA_W-1:BYTE_W];

   `BPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_bundle), "rsp changed while stalled")
   `BPR_ASSERT_IMPL(a_total_only_last, clock, reset, rsp_tvalid && !rsp_tlast, rsp_total == '0, "count on non-last byte")
   `BPR_ASSERT_IMPL(a_empty_after_reset, clock, reset, $fell(reset), !rsp_tvalid, "rsp valid right after reset")

endmodule

bind byte_pattern_replace bpr_assert_checker u_bpr_assert_checker (.*);

>>> tb/sv/bpr_checker.sv
module bpr_checker
   import bpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] out_byte, [23:8] replace_total
   input  logic                  rsp_tlast,
   input  logic                  rsp_tuser,   // [0] was_replaced
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PATTERN_MAX = 8;

   logic [LEN_W-1:0]      len_reg;
   logic [CSR_DATA_W-1:0] pat_reg;
   logic [CSR_DATA_W-1:0] rep_reg;

   logic [BYTE_W-1:0]  win_byte [PATTERN_MAX];
   logic               win_mark [PATTERN_MAX];
   int unsigned        win_fill;
   int unsigned        cooldown;
   logic [TOTAL_W-1:0] tally;

   result_type out_q [$];

   // bytes that leave the window for one accepted input byte
   function automatic void window_step(input logic [BYTE_W-1:0] value, input logic flush);
      logic [BYTE_W-1:0] seq [PATTERN_MAX+1];
      logic              mk [PATTERN_MAX+1];
      int unsigned       size, fill, cnt, first, i;
      logic              enabled, hit;
      result_type        r;
      enabled = (len_reg != 0);
      size = (len_reg == 0) ? 1 : len_reg;
      if (size > PATTERN_MAX) size = PATTERN_MAX;
      fill = win_fill;
      for (i = 0; i < fill; i++) begin
         seq[i] = win_byte[i];
         mk[i] = win_mark[i];
      end
      seq[fill] = value;
      mk[fill] = 1'b0;
      cnt = fill + 1;

      if (fill == size - 1 && cooldown == 0) begin
         hit = enabled;
         for (i = 0; i < size; i++) begin
            if (seq[i] != pat_reg[8*i +: 8]) hit = 1'b0;
         end
         if (hit) begin
            for (i = 0; i < size; i++) begin
               seq[i] = rep_reg[8*i +: 8];
               mk[i] = 1'b1;
            end
            if (tally != '1) tally++;
            cooldown = size - 1;
         end
      end else if (cooldown != 0) begin
         cooldown--;
      end

      if (flush) begin
         // whole window drains, count rides on the final byte
         for (i = 0; i < cnt; i++) begin
            r.data = seq[i];
            r.mark = mk[i];
            r.last = (i == cnt - 1);
            r.total = r.last ? tally : '0;
            out_q.push_back(r);
         end
         win_fill = 0;
         cooldown = 0;
         tally = '0;
      end else begin
         first = 0;
         if (fill + 1 >= size) begin
            r.data = seq[0];
            r.mark = mk[0];
            r.last = 1'b0;
            r.total = '0;
            out_q.push_back(r);
            first = 1;
         end
         for (i = first; i < cnt; i++) begin
            win_byte[i-first] = seq[i];
            win_mark[i-first] = mk[i];
         end
         win_fill = cnt - first;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         len_reg = 1;
         pat_reg = '0;
         rep_reg = '0;
         for (int i = 0; i < PATTERN_MAX; i++) begin
            win_byte[i] = '0;
            win_mark[i] = 1'b0;
         end
         win_fill = 0;
         cooldown = 0;
         tally = '0;
         out_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_LEN:   len_reg = csr_wdata[LEN_W-1:0];
               CSR_PATTERN_BYTES: pat_reg = csr_wdata;
               CSR_REPLACE_BYTES: rep_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) window_step(req_tdata[7:0], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (out_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction byte %h mark %b last %b total %0d",
                        $time, rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[23:8]);
            end else begin
               want = out_q.pop_front();
               if (rsp_tdata[7:0] !== want.data || rsp_tuser !== want.mark ||
                   rsp_tlast !== want.last || rsp_tdata[23:8] !== want.total) begin
                  errors++;
                  $display("%0t: expected byte %h mark %b last %b total %0d, got byte %h mark %b last %b total %0d",
                           $time, want.data, want.mark, want.last, want.total,
                           rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[23:8]);
               end
            end
         end
      end
      pending = out_q.size();
   end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpr_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] in_byte
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // [7:0] out_byte, [23:8] replace_total
   logic                  rsp_tlast;
   logic                  rsp_tuser;       // [0] was_replaced
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_PATTERN_LEN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int   errors;
   int   pending;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   bytes_sent = 0;
   logic hold_rsp = 1'b0;
   logic hold_taken = 1'b0;
   int   stall_left = 0;

   always #2 clock = ~clock;

   byte_pattern_replace u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bpr_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending)
   );

   // receiver: random backpressure plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_rsp && !hold_taken) begin
         hold_taken <= 1'b1;
         stall_left <= 250;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic final_byte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= final_byte;
      do @(posedge clock); while (req_tready !== 1'b1);
      bytes_sent++;
   endtask

   // all results drained, then an idle wait for work still inside the window
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [63:0] len_word, input logic [63:0] pat,
                            input logic [63:0] rep);
      csr_we <= 1'b1;
      csr_index <= CSR_PATTERN_LEN;
      csr_wdata <= len_word;
      @(posedge clock);
      csr_index <= CSR_PATTERN_BYTES;
      csr_wdata <= pat;
      @(posedge clock);
      csr_index <= CSR_REPLACE_BYTES;
      csr_wdata <= rep;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // one buffer built mostly from pattern copies, with broken copies and noise
   task automatic random_buffer();
      logic [7:0]  stream_q [$];
      logic [63:0] len_word, pat, rep, bent;
      int          size, pieces, part, cut, k, j, change_at;
      len_word = {$urandom, $urandom};
      case ($urandom_range(9))
         0:       len_word[3:0] = 4'd0;
         1:       len_word[3:0] = 4'($urandom_range(15, 9));
         default: len_word[3:0] = 4'($urandom_range(8, 1));
      endcase
      size = (len_word[3:0] == 0) ? 1 : ((len_word[3:0] > 8) ? 8 : len_word[3:0]);
      case ($urandom_range(7))
         0, 1:    pat = {8{8'($urandom)}};
         2:       pat = '0;
         3:       pat = '1;
         default: pat = {$urandom, $urandom};
      endcase
      case ($urandom_range(5))
         0:       rep = '0;
         1:       rep = '1;
         default: rep = {$urandom, $urandom};
      endcase
      wait_idle();
      configure(len_word, pat, rep);

      pieces = $urandom_range(10, 1);
      for (k = 0; k < pieces; k++) begin
         part = $urandom_range(9);
         bent = pat;
         if (part < 5) begin
            cut = size;
         end else if (part < 7) begin
            cut = $urandom_range(size - 1, 0);
         end else if (part == 7) begin
            cut = size;
            bent[$urandom_range(8*size - 1, 0)] ^= 1'b1;
         end else begin
            cut = 0;
         end
         for (j = 0; j < cut; j++) stream_q.push_back(bent[8*j +: 8]);
         if (part >= 8 || (part >= 5 && $urandom_range(1) == 1))
            stream_q.push_back(8'($urandom));
      end
      if (stream_q.size() == 0) stream_q.push_back(8'($urandom));

      // now and then the length changes with bytes still in the window
      change_at = ($urandom_range(6) == 0) ? $urandom_range(stream_q.size() - 1, 0) : -1;
      for (k = 0; k < stream_q.size(); k++) begin
         if (k == change_at && k > 0) begin
            wait_idle();
            len_word[3:0] = 4'($urandom_range(8, 1));
            configure(len_word, pat, rep);
         end
         send_byte(stream_q[k], k == stream_q.size() - 1);
      end
   endtask

   initial begin
      int k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 12;
      recv_idle_pct <= 65;

      // reset settings: one-byte pattern 00 replaced by 00
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);

      // run of equal bytes against a repeating pattern: no overlapping matches
      wait_idle();
      configure(64'd3, 64'h41_4141, 64'h5A_5958);
      repeat (6) send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b1);

      // length above the maximum acts as eight
      wait_idle();
      configure(64'd15, '1, 64'h0123_4567_89AB_CDEF);
      repeat (7) send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);

      // length zero passes bytes through
      wait_idle();
      configure(64'd0, '0, '1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);

      // length shrinks with a fuller window
      wait_idle();
      configure(64'd4, 64'h4433_2211, 64'hDDCC_BBAA);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      wait_idle();
      configure(64'd2, 64'h4433_2211, 64'hDDCC_BBAA);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b1);

      // long receiver hold-off while bytes keep coming
      wait_idle();
      hold_rsp <= 1'b1;
      for (k = 0; k < 40; k++) send_byte(8'($urandom), k == 39);

      while (bytes_sent < 170) random_buffer();

      wait_idle();
      send_idle_pct = 65;
      recv_idle_pct <= 12;
      while (bytes_sent < 320) random_buffer();

      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      while (bytes_sent < 460) random_buffer();

      wait_idle();
      repeat (16) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> byte_pattern_replace.f
+incdir+rtl
rtl/bpr_pkg.sv
rtl/bpr_cell.sv
rtl/bpr_out_fifo.sv
rtl/byte_pattern_replace.sv
rtl/bpr_checker.sv
tb/sv/bpr_checker.sv
tb/sv/tb_top.sv
